// ===== rtl/sdci_pkg.sv =====
// ----------------------------------------------------------------------------
// sdci_pkg
// Shared types and codes for the SD card identification sequencer.
// ----------------------------------------------------------------------------
package sdci_pkg;

  // Sequence phases, one-hot coded.
  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_CMD0   = 11'b000_0000_0010,
    PH_CMD8   = 11'b000_0000_0100,
    PH_CMD55  = 11'b000_0000_1000,
    PH_ACMD41 = 11'b000_0001_0000,
    PH_CMD2   = 11'b000_0010_0000,
    PH_CMD3   = 11'b000_0100_0000,
    PH_CMD9   = 11'b000_1000_0000,
    PH_CMD7   = 11'b001_0000_0000,
    PH_CMD16  = 11'b010_0000_0000,
    PH_DONE   = 11'b100_0000_0000
  } phase_t;

  // Input operations.
  localparam logic OP_START      = 1'b0;
  localparam logic OP_COMPLETION = 1'b1;

  // Completion status codes.
  localparam logic [1:0] CS_OK        = 2'd0;
  localparam logic [1:0] CS_TIMEOUT   = 2'd1;
  localparam logic [1:0] CS_CRC       = 2'd2;
  localparam logic [1:0] CS_NO_ANSWER = 2'd3;

  // Final status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
  localparam logic [2:0] ST_NOT_READY   = 3'd5;

  // Expected response kinds.
  localparam logic [1:0] RSP_NONE  = 2'd0;
  localparam logic [1:0] RSP_SHORT = 2'd1;
  localparam logic [1:0] RSP_LONG  = 2'd2;

  // Card kinds.
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_SDSC    = 2'd1;
  localparam logic [1:0] KIND_SDHC    = 2'd2;

  // Command indexes.
  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_ALL_CID    = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
  localparam logic [5:0] CMD_SELECT     = 6'd7;
  localparam logic [5:0] CMD_IF_COND    = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
  localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
  localparam logic [5:0] CMD_OP_COND    = 6'd41;
  localparam logic [5:0] CMD_APP_CMD    = 6'd55;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] CFG_OP_COND_ARG = 2'd1;
  localparam logic [1:0] CFG_BLOCK_LEN   = 2'd2;

  // Configuration reset values.
  localparam logic [11:0] RETRY_LIMIT_RESET = 12'd2000;
  localparam logic [31:0] OP_COND_ARG_RESET = 32'h4030_0000;
  localparam logic [15:0] BLOCK_LEN_RESET   = 16'd512;

  // Check pattern for CMD8 and OCR bits.
  localparam logic [11:0] IF_COND_PATTERN = 12'h1AA;
  localparam int          OCR_BUSY_BIT    = 31;
  localparam int          OCR_CCS_BIT     = 30;

  // One result item.
  typedef struct packed {
    logic        issue_command;
    logic        wait_first;
    logic [5:0]  command_index;
    logic [31:0] command_argument;
    logic [1:0]  response_kind;
    logic        finished;
    logic [2:0]  final_status;
    logic [1:0]  card_kind;
    logic [15:0] card_address;
    logic [32:0] card_blocks;
  } result_t;

endpackage

// ===== rtl/sd_card_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_card_init_sequencer
// SD card identification sequencer: issues CMD0, CMD8, CMD55/ACMD41, CMD2,
// CMD3, CMD9, CMD7 and CMD16 and reports card type, RCA and capacity.
// ----------------------------------------------------------------------------
// Each accepted item (a start or a command completion) produces exactly one
// result item: the item is captured in an input register, the next command
// or the final status is decided in one short pass and written to the result
// register together with the phase and card data. Both registers advance
// independently, so one item per cycle is sustained while out_ready takes
// each result; the input side keeps accepting while a result waits to be
// taken until both registers are full. Configuration writes are taken every
// cycle. response_word3 carries CSD bits that this sequencer does not use.
module sd_card_init_sequencer (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [1:0]  completion_status,
  input  logic [31:0] response_word0,
  input  logic [31:0] response_word1,
  input  logic [31:0] response_word2,
  input  logic [31:0] response_word3,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        issue_command,
  output logic        wait_first,
  output logic [5:0]  command_index,
  output logic [31:0] command_argument,
  output logic [1:0]  response_kind,
  output logic        finished,
  output logic [2:0]  final_status,
  output logic [1:0]  card_kind,
  output logic [15:0] card_address,
  output logic [32:0] card_blocks
);

  import sdci_pkg::*;

  // Configuration registers.
  logic [11:0] retry_limit;
  logic [31:0] op_cond_arg;
  logic [15:0] block_len;

  // Input stage.
  logic        in_full;
  logic        in_op;
  logic [1:0]  in_status;
  logic [31:0] in_w0;
  logic [31:0] in_w1;
  logic [31:0] in_w2;

  // Sequence state.
  phase_t      phase;
  phase_t      phase_next;
  logic [11:0] retry_count;
  logic [11:0] retry_count_next;
  logic [1:0]  kind_reg;
  logic [1:0]  kind_reg_next;
  logic [15:0] address_reg;
  logic [15:0] address_reg_next;
  logic [32:0] blocks_reg;
  logic [32:0] blocks_reg_next;

  // Result stage.
  result_t     res;
  result_t     res_next;

  logic        advance;
  logic [11:0] retry_inc;
  logic [31:0] rca_arg;
  logic [32:0] csd_blocks;

  assign cfg_ready = 1'b1;
  assign advance   = ~out_valid | out_ready;
  assign in_ready  = ~in_full | advance;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RESET;
      op_cond_arg <= OP_COND_ARG_RESET;
      block_len   <= BLOCK_LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RETRY_LIMIT: retry_limit <= cfg_data[11:0];
        CFG_OP_COND_ARG: op_cond_arg <= cfg_data;
        CFG_BLOCK_LEN:   block_len   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op     <= opcode;
      in_status <= completion_status;
      in_w0     <= response_word0;
      in_w1     <= response_word1;
      in_w2     <= response_word2;
    end
  end

  // Capacity from a version 2 CSD: (C_SIZE + 1) * 1024 blocks.
  always_comb begin
    logic [22:0] c_size_p1;
    c_size_p1 = {1'b0, in_w1[5:0], in_w2[31:16]} + 23'd1;
    if (in_w0[31:30] == 2'b01) begin
      csd_blocks = {c_size_p1, 10'd0};
    end else begin
      csd_blocks = '0;
    end
  end

  assign retry_inc = retry_count + 12'd1;
  assign rca_arg   = {address_reg, 16'd0};

  // Next command or final status for the item in the input register.
  always_comb begin
    phase_next       = phase;
    retry_count_next = retry_count;
    kind_reg_next    = kind_reg;
    address_reg_next = address_reg;
    blocks_reg_next  = blocks_reg;
    res_next         = '0;

    if (in_op == OP_START) begin
      retry_count_next        = '0;
      kind_reg_next           = KIND_UNKNOWN;
      address_reg_next        = '0;
      blocks_reg_next         = '0;
      phase_next              = PH_CMD0;
      res_next.issue_command  = 1'b1;
      res_next.command_index  = CMD_GO_IDLE;
      res_next.response_kind  = RSP_NONE;
    end else begin
      case (phase)
        PH_CMD0: begin
          if (in_status != CS_OK) begin
            res_next.finished     = 1'b1;
            res_next.final_status = {1'b0, in_status};
          end else begin
            phase_next                = PH_CMD8;
            res_next.issue_command    = 1'b1;
            res_next.command_index    = CMD_IF_COND;
            res_next.command_argument = {20'd0, IF_COND_PATTERN};
            res_next.response_kind    = RSP_SHORT;
          end
        end
        PH_CMD8: begin
          if (in_status != CS_OK || in_w0[11:0] != IF_COND_PATTERN) begin
            res_next.finished     = 1'b1;
            res_next.final_status = ST_UNSUPPORTED;
          end else begin
            retry_count_next          = '0;
            phase_next                = PH_CMD55;
            res_next.issue_command    = 1'b1;
            res_next.command_index    = CMD_APP_CMD;
            res_next.command_argument = rca_arg;
            res_next.response_kind    = RSP_SHORT;
          end
        end
        PH_CMD55: begin
          if (in_status != CS_OK) begin
            res_next.finished     = 1'b1;
            res_next.final_status = {1'b0, in_status};
          end else begin
            phase_next                = PH_ACMD41;
            res_next.issue_command    = 1'b1;
            res_next.command_index    = CMD_OP_COND;
            res_next.command_argument = op_cond_arg;
            res_next.response_kind    = RSP_SHORT;
          end
        end
        PH_ACMD41: begin
          // A CRC error is expected here and treated as success.
          if (in_status == CS_TIMEOUT || in_status == CS_NO_ANSWER) begin
            res_next.finished     = 1'b1;
            res_next.final_status = {1'b0, in_status};
          end else if (in_w0[OCR_BUSY_BIT]) begin
            kind_reg_next          = in_w0[OCR_CCS_BIT] ? KIND_SDHC : KIND_SDSC;
            phase_next             = PH_CMD2;
            res_next.issue_command = 1'b1;
            res_next.command_index = CMD_ALL_CID;
            res_next.response_kind = RSP_LONG;
          end else begin
            retry_count_next = retry_inc;
            if (retry_inc >= retry_limit) begin
              res_next.finished     = 1'b1;
              res_next.final_status = ST_NOT_READY;
            end else begin
              phase_next                = PH_CMD55;
              res_next.issue_command    = 1'b1;
              res_next.wait_first       = 1'b1;
              res_next.command_index    = CMD_APP_CMD;
              res_next.command_argument = rca_arg;
              res_next.response_kind    = RSP_SHORT;
            end
          end
        end
        PH_CMD2: begin
          if (in_status != CS_OK) begin
            res_next.finished     = 1'b1;
            res_next.final_status = {1'b0, in_status};
          end else begin
            phase_next             = PH_CMD3;
            res_next.issue_command = 1'b1;
            res_next.command_index = CMD_SEND_RCA;
            res_next.response_kind = RSP_SHORT;
          end
        end
        PH_CMD3: begin
          if (in_status != CS_OK) begin
            res_next.finished     = 1'b1;
            res_next.final_status = {1'b0, in_status};
          end else begin
            address_reg_next          = in_w0[31:16];
            phase_next                = PH_CMD9;
            res_next.issue_command    = 1'b1;
            res_next.command_index    = CMD_SEND_CSD;
            res_next.command_argument = {in_w0[31:16], 16'd0};
            res_next.response_kind    = RSP_LONG;
          end
        end
        PH_CMD9: begin
          if (in_status != CS_OK) begin
            res_next.finished     = 1'b1;
            res_next.final_status = {1'b0, in_status};
          end else begin
            blocks_reg_next           = csd_blocks;
            phase_next                = PH_CMD7;
            res_next.issue_command    = 1'b1;
            res_next.command_index    = CMD_SELECT;
            res_next.command_argument = rca_arg;
            res_next.response_kind    = RSP_SHORT;
          end
        end
        PH_CMD7: begin
          if (in_status != CS_OK) begin
            res_next.finished     = 1'b1;
            res_next.final_status = {1'b0, in_status};
          end else begin
            phase_next                = PH_CMD16;
            res_next.issue_command    = 1'b1;
            res_next.command_index    = CMD_BLOCKLEN;
            res_next.command_argument = {16'd0, block_len};
            res_next.response_kind    = RSP_SHORT;
          end
        end
        PH_CMD16: begin
          res_next.finished     = 1'b1;
          res_next.final_status = {1'b0, in_status};
        end
        default: ;
      endcase
      // Every ending goes to the done phase.
      if (res_next.finished) begin
        phase_next = PH_DONE;
      end
    end

    res_next.card_kind    = kind_reg_next;
    res_next.card_address = address_reg_next;
    res_next.card_blocks  = blocks_reg_next;
  end

  // Sequence state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      retry_count <= '0;
      kind_reg    <= KIND_UNKNOWN;
      address_reg <= '0;
      blocks_reg  <= '0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
      if (in_full) begin
        phase       <= phase_next;
        retry_count <= retry_count_next;
        kind_reg    <= kind_reg_next;
        address_reg <= address_reg_next;
        blocks_reg  <= blocks_reg_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      res <= res_next;
    end
  end

  assign issue_command    = res.issue_command;
  assign wait_first       = res.wait_first;
  assign command_index    = res.command_index;
  assign command_argument = res.command_argument;
  assign response_kind    = res.response_kind;
  assign finished         = res.finished;
  assign final_status     = res.final_status;
  assign card_kind        = res.card_kind;
  assign card_address     = res.card_address;
  assign card_blocks      = res.card_blocks;

`ifndef SYNTH
  // A result never both issues a command and ends the sequence.
  a_cmd_or_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(issue_command && finished))
    else $error("result both issues a command and finishes");

  // Unused command fields are zero when no command is issued.
  a_idle_cmd_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !issue_command) |->
      (!wait_first && command_index == CMD_GO_IDLE && command_argument == '0 &&
       response_kind == RSP_NONE))
    else $error("command fields not cleared without a command");

  // A held input item stays in the input register until it moves on.
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_op) && $stable(in_status)))
    else $error("input register lost a waiting item");

  // The state only moves when an item passes to the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && in_full) |=> ($stable(phase) && $stable(retry_count)))
    else $error("sequence state changed without an item");

  // The retry counter only grows while polling the operating condition.
  a_retry_grow: assert property (@(posedge clk) disable iff (rst)
    (retry_count != $past(retry_count) && retry_count != '0) |->
      ($past(phase) == PH_ACMD41))
    else $error("retry counter changed outside ACMD41");
`endif

endmodule
